// ===== src/prefix_add_stack_mean_core_macros.svh =====
// ---------------------------------------------------------------------------
// prefix_add_stack_mean_core assertion macros
// property forms used by the stack core's checks
// ---------------------------------------------------------------------------
`ifndef PREFIX_ADD_STACK_MEAN_CORE_MACROS_SVH
`define PREFIX_ADD_STACK_MEAN_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define PASM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define PASM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pasm_pkg.sv =====
// ---------------------------------------------------------------------------
// pasm_pkg
// types, codes and widths shared by the prefix-add stack core
// ---------------------------------------------------------------------------
package pasm_pkg;

  localparam int DEPTH_DEFAULT         = 1024;
  localparam int ELEMENT_WIDTH_DEFAULT = 32;

  localparam int REQ_WIDTH     = 2;
  localparam int COUNT_WIDTH   = 11;
  localparam int OPERAND_WIDTH = 16;
  localparam int LENGTH_WIDTH  = 11;
  localparam int TOTAL_WIDTH   = 48;
  localparam int MEAN_WIDTH    = 40;
  localparam int MEAN_SHIFT    = 8;

  // request codes; the unused code decodes as a pop
  localparam logic [REQ_WIDTH-1:0] REQ_ADD  = 2'd0;
  localparam logic [REQ_WIDTH-1:0] REQ_PUSH = 2'd1;
  localparam logic [REQ_WIDTH-1:0] REQ_POP  = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_COUNT = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_LAST      = 2'd3
  } pasm_status_t;

  typedef struct packed {
    logic [REQ_WIDTH-1:0]            req_type;
    logic [COUNT_WIDTH-1:0]          prefix_count;
    logic signed [OPERAND_WIDTH-1:0] operand_value;
  } pasm_req_t;

  typedef struct packed {
    pasm_status_t                  status;
    logic [LENGTH_WIDTH-1:0]       length;
    logic signed [TOTAL_WIDTH-1:0] total;
    logic signed [MEAN_WIDTH-1:0]  mean_q8;
  } pasm_rsp_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pasm_div_stat_t;

endpackage

// ===== src/prefix_add_stack_mean_core.sv =====
// ---------------------------------------------------------------------------
// prefix_add_stack_mean_core
// stack of signed elements with prefix add, push and pop, reporting the
// length, running total and q8 mean after every request
// ---------------------------------------------------------------------------
// The sequence starts as one zero element. It is held as neighbor
// differences in a single-port-write, registered-read memory plus the top
// element, so every request touches at most one memory word. From its
// transfer to the response being loaded, a request passes these steps
// in order: the memory read, modify and write back, loading the divider,
// the bit-serial mean divider (one quotient bit per cycle for the 56-bit
// total*256), signing and clamping the quotient, and loading the response
// register once it is free or its contents are being taken. A
// new request is taken as soon as the previous response sits in the output
// register, even if it has not been taken yet. The memory needs no clearing
// pass after reset: an entry is only read below index length-1, and every
// such entry was written by the push that grew the stack past it. Bad
// prefix counts, pushes when full and pops of the last element are flagged
// in the status and change nothing.
// ---------------------------------------------------------------------------
module prefix_add_stack_mean_core #(
  parameter int DEPTH         = pasm_pkg::DEPTH_DEFAULT,
  parameter int ELEMENT_WIDTH = pasm_pkg::ELEMENT_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  pasm_pkg::pasm_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output pasm_pkg::pasm_rsp_t rsp
);

  import pasm_pkg::*;

  `include "prefix_add_stack_mean_core_macros.svh"

  localparam int LenWidth  = $clog2(DEPTH + 1);
  localparam int AddrWidth = $clog2(DEPTH);
  localparam int CmpWidth  = (LenWidth > COUNT_WIDTH) ? LenWidth : COUNT_WIDTH;
  localparam int ProdWidth = COUNT_WIDTH + 1 + OPERAND_WIDTH;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MOD   = 5'b00010,
    ST_START = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // architectural state
  logic [LenWidth-1:0]           seq_length;
  logic [ELEMENT_WIDTH-1:0]      top_value;
  logic signed [TOTAL_WIDTH-1:0] total;

  // per-request registers captured at the transfer
  logic [REQ_WIDTH-1:0]            op;
  pasm_status_t                    status;
  logic                            on_top;
  logic [AddrWidth-1:0]            addr;
  logic signed [OPERAND_WIDTH-1:0] operand;
  logic signed [ProdWidth-1:0]     prod;

  // request decode
  logic [CmpWidth-1:0]      cnt_ext;
  logic [CmpWidth-1:0]      len_ext;
  logic [REQ_WIDTH-1:0]     dec_op;
  pasm_status_t             dec_status;
  logic [AddrWidth-1:0]     dec_addr;
  logic                     accept;

  // memory port
  logic                     mem_we;
  logic [ELEMENT_WIDTH-1:0] mem_wdata;
  logic [ELEMENT_WIDTH-1:0] mem_rdata;
  logic [ELEMENT_WIDTH-1:0] operand_el;

  // divider
  pasm_div_stat_t               div_stat;
  logic signed [MEAN_WIDTH-1:0] div_quotient;
  logic                         rsp_load;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign cnt_ext   = CmpWidth'(req.prefix_count);
  assign len_ext   = CmpWidth'(seq_length);

  // status and memory address of the incoming request
  always_comb begin
    dec_status = STAT_OK;
    dec_op     = REQ_POP;
    dec_addr   = AddrWidth'(len_ext - CmpWidth'(2));
    case (req.req_type)
      REQ_ADD: begin
        dec_op   = REQ_ADD;
        dec_addr = AddrWidth'(cnt_ext - CmpWidth'(1));
        if (cnt_ext == '0 || cnt_ext > len_ext) begin
          dec_status = STAT_BAD_COUNT;
        end
      end
      REQ_PUSH: begin
        dec_op   = REQ_PUSH;
        dec_addr = AddrWidth'(len_ext - CmpWidth'(1));
        if (seq_length >= LenWidth'(DEPTH)) begin
          dec_status = STAT_FULL;
        end
      end
      default: begin
        // pop, and the unused code
        if (seq_length == LenWidth'(1)) begin
          dec_status = STAT_LAST;
        end
      end
    endcase
  end

  // capture the request; the product is registered ahead of the total add
  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= dec_op;
      status  <= dec_status;
      on_top  <= (cnt_ext == len_ext);
      addr    <= dec_addr;
      operand <= req.operand_value;
      prod    <= ProdWidth'($signed({1'b0, req.prefix_count})) *
                 ProdWidth'(req.operand_value);
    end
  end

  assign operand_el = ELEMENT_WIDTH'(operand);

  // write back: adds below the top and pushes touch the memory, a pop only
  // reads its entry, which then lies at index length-1 and is never read again
  // before a push writes it
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = top_value - operand_el;
    if (state == ST_MOD && status == STAT_OK) begin
      if (op == REQ_ADD) begin
        mem_we    = !on_top;
        mem_wdata = mem_rdata + operand_el;
      end else if (op == REQ_PUSH) begin
        mem_we = 1'b1;
      end
    end
  end

  // read issued at the transfer, data used in the modify cycle; the next
  // read cannot start before this write lands, so no forwarding is needed
  pasm_diff_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (ELEMENT_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (dec_addr),
    .rdata (mem_rdata)
  );

  // state update in the modify cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_length <= LenWidth'(1);
      top_value  <= '0;
      total      <= '0;
    end else if (state == ST_MOD && status == STAT_OK) begin
      case (op)
        REQ_ADD: begin
          if (on_top) begin
            top_value <= top_value + operand_el;
          end
          total <= total + TOTAL_WIDTH'(prod);
        end
        REQ_PUSH: begin
          top_value  <= operand_el;
          seq_length <= seq_length + LenWidth'(1);
          total      <= total + TOTAL_WIDTH'(operand);
        end
        default: begin
          top_value  <= top_value + mem_rdata;
          seq_length <= seq_length - LenWidth'(1);
          total      <= total - TOTAL_WIDTH'($signed(top_value));
        end
      endcase
    end
  end

  // mean of the updated total over the updated length
  pasm_divider #(
    .LEN_WIDTH (LenWidth)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_START),
    .dividend (total),
    .divisor  (seq_length),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  // sequencer
  assign rsp_load = (state == ST_OUT) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_MOD;
      ST_MOD:   state_next = ST_START;
      ST_START: state_next = ST_DIV;
      ST_DIV:   if (div_stat.done) state_next = ST_OUT;
      ST_OUT:   if (rsp_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // response register; it frees the core while the result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status  <= status;
      rsp.length  <= LENGTH_WIDTH'(seq_length);
      rsp.total   <= total;
      rsp.mean_q8 <= div_quotient;
    end
  end

  // checks
  `PASM_ASSERT_IMP(a_len_range, clk, rst, 1'b1, (seq_length != '0) && (seq_length <= LenWidth'(DEPTH)), "stack length out of range")
  `PASM_ASSERT_IMP(a_ready_div_idle, clk, rst, req_ready, !div_stat.busy, "request taken while the divider runs")
  `PASM_ASSERT_IMP(a_write_in_mod, clk, rst, mem_we, state == ST_MOD, "memory written outside the modify cycle")
  `PASM_ASSERT_NXT(a_transfer_to_mod, clk, rst, accept, state == ST_MOD, "transfer not followed by modify cycle")

endmodule

// ===== src/pasm_diff_mem.sv =====
// ---------------------------------------------------------------------------
// pasm_diff_mem
// neighbor-difference store: one write port, one registered read port
// ---------------------------------------------------------------------------
module pasm_diff_mem #(
  parameter int DEPTH      = pasm_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = pasm_pkg::ELEMENT_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(DEPTH)-1:0]      waddr,
  input  logic [DATA_WIDTH-1:0]         wdata,
  input  logic                          re,
  input  logic [$clog2(DEPTH)-1:0]      raddr,
  output logic [DATA_WIDTH-1:0]         rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/pasm_divider.sv =====
// ---------------------------------------------------------------------------
// pasm_divider
// bit-serial signed divide of total*256 by the length, saturated to q8 range
// ---------------------------------------------------------------------------
module pasm_divider #(
  parameter int LEN_WIDTH = 11
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  input  logic signed [pasm_pkg::TOTAL_WIDTH-1:0]  dividend,
  input  logic [LEN_WIDTH-1:0]                     divisor,
  output pasm_pkg::pasm_div_stat_t                 stat,
  output logic signed [pasm_pkg::MEAN_WIDTH-1:0]   quotient
);

  import pasm_pkg::*;

  localparam int QuoWidth = TOTAL_WIDTH + MEAN_SHIFT;
  localparam int CntWidth = $clog2(QuoWidth + 1);
  localparam logic [QuoWidth-1:0] MaxMag =
    {{(QuoWidth - MEAN_WIDTH + 1){1'b0}}, {(MEAN_WIDTH - 1){1'b1}}};
  localparam logic [QuoWidth-1:0] MinMag = MaxMag + QuoWidth'(1);

  logic                   busy;
  logic                   finish;
  logic                   done;
  logic                   neg;
  logic [CntWidth-1:0]    count;
  logic [LEN_WIDTH-1:0]   div_r;
  logic [LEN_WIDTH-1:0]   rem;
  logic [QuoWidth-1:0]    quo;
  logic [TOTAL_WIDTH-1:0] dv;
  logic [TOTAL_WIDTH-1:0] mag;
  logic [LEN_WIDTH:0]     trial;
  logic [LEN_WIDTH:0]     diff;
  logic                   fits;
  logic [MEAN_WIDTH-1:0]  low;

  assign dv    = dividend;
  assign mag   = dv[TOTAL_WIDTH-1] ? (~dv + TOTAL_WIDTH'(1)) : dv;
  assign trial = {rem, quo[QuoWidth-1]};
  assign diff  = trial - {1'b0, div_r};
  assign fits  = trial >= {1'b0, div_r};
  assign low   = quo[MEAN_WIDTH-1:0];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      finish <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CntWidth'(QuoWidth);
      end else if (busy) begin
        count <= count - CntWidth'(1);
        if (count == CntWidth'(1)) begin
          busy   <= 1'b0;
          finish <= 1'b1;
        end
      end else if (finish) begin
        finish <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  // datapath: one quotient bit per cycle, sign and clamp at the end
  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= dv[TOTAL_WIDTH-1];
      div_r <= divisor;
      rem   <= '0;
      quo   <= {mag, {MEAN_SHIFT{1'b0}}};
    end else if (busy) begin
      rem <= fits ? diff[LEN_WIDTH-1:0] : trial[LEN_WIDTH-1:0];
      quo <= {quo[QuoWidth-2:0], fits};
    end else if (finish) begin
      if (!neg) begin
        quotient <= (quo > MaxMag) ? {1'b0, {(MEAN_WIDTH - 1){1'b1}}} : low;
      end else begin
        quotient <= (quo > MinMag) ? {1'b1, {(MEAN_WIDTH - 1){1'b0}}}
                                   : (~low + MEAN_WIDTH'(1));
      end
    end
  end

  assign stat.busy = busy | finish;
  assign stat.done = done;

endmodule

// ===== bench/prefix_add_stack_mean_core_tb.sv =====
// ---------------------------------------------------------------------------
// prefix_add_stack_mean_core_tb
// self-checking bench for the prefix-add stack core: directed corner
// requests, then random sequences that fill the stack to depth and shrink it,
// with each response checked field by field against a cycle-free predictor
// ---------------------------------------------------------------------------
module prefix_add_stack_mean_core_tb;
  import pasm_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEFAULT;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int ELEM_W      = ELEMENT_WIDTH_DEFAULT;
  localparam int ITEM_GOAL   = 1950;
  localparam int IDLE_PCT    = 13;
  localparam int SHOW_LIMIT  = 20;
  // drain adds idle margin after the last response has been checked
  localparam int DRAIN_CYCLES = 150;

  // the package names three request codes; the fourth decodes as a pop
  localparam logic [REQ_WIDTH-1:0] REQ_SPARE = 2'd3;

  localparam longint MEAN_HI = 64'sd549755813887;
  localparam longint MEAN_LO = -64'sd549755813888;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  pasm_req_t req       = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  pasm_rsp_t rsp;

  prefix_add_stack_mean_core u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state: neighbor differences, top element, length, running sum
  logic [ELEM_W-1:0] diff_mem [STACK_DEPTH];
  logic [ELEM_W-1:0] top_elem;
  int unsigned       stack_len;
  logic [47:0]       run_total;

  // stimulus backlog, expected responses and bookkeeping
  pasm_req_t   req_backlog [$];
  pasm_rsp_t   awaited_rsp [$];
  int unsigned plan_len;
  int          items_planned = 0;
  int          reqs_sent     = 0;
  int          reqs_taken    = 0;
  int          rsps_checked  = 0;
  int          mismatches    = 0;
  int          status_seen [4];
  int unsigned peak_len      = 1;

  // apply one request to the predictor state, return the response it gives
  function automatic pasm_rsp_t apply_request(input pasm_req_t r);
    pasm_rsp_t         res;
    logic [ELEM_W-1:0] amt;
    longint            prod;
    longint            t;
    longint            q;
    logic [IDX_W-1:0]  idx;
    amt = {{(ELEM_W-OPERAND_WIDTH){r.operand_value[OPERAND_WIDTH-1]}}, r.operand_value};
    res.status = STAT_OK;
    case (r.req_type)
      REQ_ADD: begin
        if (r.prefix_count == 0 || r.prefix_count > stack_len) begin
          res.status = STAT_BAD_COUNT;
        end else begin
          // adding to the whole stack lands on the top element, otherwise
          // on the difference just below the prefix boundary
          if (r.prefix_count == stack_len) begin
            top_elem = top_elem + amt;
          end else begin
            idx = IDX_W'(r.prefix_count - 1'b1);
            diff_mem[idx] = diff_mem[idx] + amt;
          end
          prod = longint'(r.prefix_count) * longint'(signed'(r.operand_value));
          run_total = run_total + prod[47:0];
        end
      end
      REQ_PUSH: begin
        if (stack_len >= STACK_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          idx = IDX_W'(stack_len - 1);
          diff_mem[idx] = top_elem - amt;
          top_elem = amt;
          stack_len++;
          run_total = run_total + {{(48-OPERAND_WIDTH){r.operand_value[OPERAND_WIDTH-1]}},
                                   r.operand_value};
        end
      end
      default: begin
        // pop, including the spare code
        if (stack_len <= 1) begin
          res.status = STAT_LAST;
        end else begin
          idx = IDX_W'(stack_len - 2);
          run_total = run_total - {{(48-ELEM_W){top_elem[ELEM_W-1]}}, top_elem};
          top_elem = top_elem + diff_mem[idx];
          diff_mem[idx] = '0;
          stack_len--;
        end
      end
    endcase
    // q8 mean, truncated toward zero, clamped to 40 bits
    t = longint'(signed'(run_total));
    q = (t * 256) / longint'(stack_len);
    if (q > MEAN_HI) q = MEAN_HI;
    if (q < MEAN_LO) q = MEAN_LO;
    res.length  = stack_len[LENGTH_WIDTH-1:0];
    res.total   = run_total;
    res.mean_q8 = q[MEAN_WIDTH-1:0];
    status_seen[res.status]++;
    if (stack_len > peak_len) peak_len = stack_len;
    return res;
  endfunction

  task automatic flag_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (mismatches < SHOW_LIMIT) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
    end
    mismatches++;
  endtask

  // queue one request and track the length it will leave behind
  task automatic queue_req(input logic [REQ_WIDTH-1:0] kind, input int cnt,
                           input logic [OPERAND_WIDTH-1:0] val);
    pasm_req_t r;
    r.req_type      = kind;
    r.prefix_count  = cnt[COUNT_WIDTH-1:0];
    r.operand_value = val;
    req_backlog.insert(req_backlog.size(), r);
    items_planned++;
    if (kind == REQ_PUSH) begin
      if (plan_len < STACK_DEPTH) plan_len++;
    end else if (kind != REQ_ADD) begin
      if (plan_len > 1) plan_len--;
    end
  endtask

  function automatic logic [OPERAND_WIDTH-1:0] pick_operand();
    case ($urandom_range(15))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return OPERAND_WIDTH'($urandom);
    endcase
  endfunction

  // one random request; push and add shares in percent, pops take the rest
  task automatic random_request(input int push_pct, input int add_pct);
    int roll;
    int cnt;
    roll = $urandom_range(99);
    if (roll < push_pct) begin
      queue_req(REQ_PUSH, $urandom_range(2047), pick_operand());
    end else if (roll < push_pct + add_pct) begin
      case ($urandom_range(9))
        0:       cnt = 0;
        1:       cnt = plan_len + 1;
        2:       cnt = $urandom_range(2047, plan_len + 1);
        3, 4:    cnt = plan_len;
        5:       cnt = 1;
        default: cnt = $urandom_range(plan_len, 1);
      endcase
      queue_req(REQ_ADD, cnt, pick_operand());
    end else begin
      queue_req(($urandom_range(9) == 0) ? REQ_SPARE : REQ_POP,
                $urandom_range(2047), OPERAND_WIDTH'($urandom));
    end
  endtask

  // monitor: check responses first, since a response at the same edge as a
  // request transfer always belongs to an earlier request
  always @(posedge clk) begin
    pasm_rsp_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp.size() == 0) begin
          if (mismatches < SHOW_LIMIT) $error("response transfer with nothing outstanding");
          mismatches++;
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.status !== want.status)   flag_mismatch("status", want.status, rsp.status);
          if (rsp.length !== want.length)   flag_mismatch("length", want.length, rsp.length);
          if (rsp.total !== want.total)     flag_mismatch("total", want.total, rsp.total);
          if (rsp.mean_q8 !== want.mean_q8) flag_mismatch("mean_q8", want.mean_q8, rsp.mean_q8);
        end
        rsps_checked++;
      end
      if (req_valid && req_ready) begin
        awaited_rsp.insert(awaited_rsp.size(), apply_request(req));
        reqs_taken++;
      end
    end
  end

  // driver: a new request goes out only once the last one was transferred;
  // both sides idle at random outside a calm window
  always @(negedge clk) begin
    logic send_calm;
    logic recv_calm;
    send_calm = (reqs_sent >= 800 && reqs_sent < 1150);
    recv_calm = (rsps_checked >= 800 && rsps_checked < 1150);
    if (!rst) begin
      if (reqs_taken == reqs_sent) begin
        if (req_backlog.size() > 0 && (send_calm || $urandom_range(99) >= IDLE_PCT)) begin
          req       <= req_backlog.pop_front();
          req_valid <= 1'b1;
          reqs_sent++;
        end else begin
          req_valid <= 1'b0;
        end
      end
      rsp_ready <= recv_calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    diff_mem    = '{default: '0};
    top_elem    = '0;
    stack_len   = 1;
    run_total   = '0;
    plan_len    = 1;
    status_seen = '{default: 0};

    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: rejections at length one, operand extremes, adds to the
    // bottom, the middle and the whole stack, negative means, spare code
    queue_req(REQ_POP,   0,    16'h0000);
    queue_req(REQ_SPARE, 2047, 16'hFFFF);
    queue_req(REQ_ADD,   0,    16'h0005);
    queue_req(REQ_ADD,   2,    16'h0005);
    queue_req(REQ_ADD,   2047, 16'h8000);
    queue_req(REQ_ADD,   1,    16'h7FFF);
    queue_req(REQ_PUSH,  0,    16'h8000);
    queue_req(REQ_PUSH,  0,    16'h7FFF);
    queue_req(REQ_ADD,   1,    16'hFFFF);
    queue_req(REQ_ADD,   3,    16'h8000);
    queue_req(REQ_ADD,   2,    16'h7FFF);
    queue_req(REQ_ADD,   4,    16'h0001);
    queue_req(REQ_PUSH,  0,    16'h0000);
    queue_req(REQ_PUSH,  0,    16'hFFFF);
    queue_req(REQ_ADD,   5,    16'hFFFD);
    queue_req(REQ_POP,   0,    16'h1234);
    queue_req(REQ_SPARE, 0,    16'h0000);
    queue_req(REQ_POP,   0,    16'h0000);
    queue_req(REQ_POP,   0,    16'h0000);
    queue_req(REQ_POP,   0,    16'h0000);
    queue_req(REQ_PUSH,  0,    16'h7FFF);
    queue_req(REQ_ADD,   1,    16'h7FFF);
    queue_req(REQ_PUSH,  0,    16'h8000);
    queue_req(REQ_ADD,   0,    16'h0000);

    // hold the sender until every outstanding response has come back
    while (req_backlog.size() > 0 || reqs_taken != reqs_sent) @(posedge clk);
    while (awaited_rsp.size() > 0) @(posedge clk);

    // mixed traffic at shallow depth
    repeat (300) random_request(35, 45);

    // grow to full depth with adds mixed in
    while (plan_len < STACK_DEPTH) random_request(85, 12);

    // at full depth: rejected pushes, adds over the whole stack and its edge
    repeat (6) queue_req(REQ_PUSH, 0, pick_operand());
    queue_req(REQ_ADD, STACK_DEPTH,     16'h7FFF);
    queue_req(REQ_ADD, STACK_DEPTH - 1, 16'h8000);
    queue_req(REQ_ADD, STACK_DEPTH + 1, 16'h0001);
    queue_req(REQ_ADD, 1,               pick_operand());
    queue_req(REQ_POP, 0,               16'h0000);
    queue_req(REQ_PUSH, 0,              16'h8000);
    queue_req(REQ_PUSH, 0,              16'h7FFF);

    // balanced traffic while the stack shrinks back
    while (items_planned < ITEM_GOAL) random_request(25, 40);

    while (req_backlog.size() > 0 || reqs_taken != reqs_sent) @(posedge clk);
    while (awaited_rsp.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests, peak stack length %0d of %0d", reqs_taken, peak_len,
             STACK_DEPTH);
    $display("status counts: ok %0d, bad count %0d, full %0d, last element %0d; %0d mismatches",
             status_seen[STAT_OK], status_seen[STAT_BAD_COUNT], status_seen[STAT_FULL],
             status_seen[STAT_LAST], mismatches);
    if (mismatches == 0) begin
      $display("PASS prefix_add_stack_mean_core");
    end else begin
      $display("FAIL prefix_add_stack_mean_core");
    end
    $finish;
  end

  // watchdog: several times the slowest expected run
  initial begin
    #4000000;
    $display("FAIL prefix_add_stack_mean_core");
    $finish;
  end

endmodule
